// File: src/trz_pkg.sv
// Shared constants and types for the triangle rasterizer with depth buffer.
// No dependencies; imported by triangle_raster_zbuffer.
package trz_pkg;

    localparam int TRZ_FRAME_WIDTH  = 256;
    localparam int TRZ_FRAME_HEIGHT = 256;
    localparam int TRZ_DEPTH_BITS   = 16;
    localparam int TRZ_TEX_BITS     = 10;

    localparam int TRZ_COORD_BITS   = 12;
    localparam int TRZ_AREA_BITS    = 27;
    localparam int TRZ_CFG_BITS     = 9;
    localparam int TRZ_PIX_BITS     = 8;

    typedef enum logic [1:0] {
        ST_OUTSIDE = 2'd0,
        ST_HIDDEN  = 2'd1,
        ST_WRITTEN = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [1:0] SLOT_START = 2'd2;
    localparam logic [1:0] SLOT_NONE  = 2'd3;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

endpackage

// File: src/triangle_raster_zbuffer.sv
// Triangle rasterizer with barycentric edge test, interpolation and depth buffer.
// Depends on trz_pkg; holds the shared multiplier, the serial divider and the depth memory.
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+---------------------
//  item in   | mode vertex_slot vertex_x/y/depth/u/v              | start & !busy
//  result    | status pixel_x/y/depth/u/v last                    | done, one cycle
//  config    | cfg_index cfg_data                                 | cfg_write
//
// After reset the depth memory is cleared, one entry a cycle, with busy high.
// A load of slot 2 computes the box and two products on the shared multiplier. A step
// on an inside pixel interpolates depth, u and v through the one multiplier and the
// one-bit-a-cycle divider, each quotient QB bits wide, QB being the wider of DEPTH_BITS
// and TEX_BITS. Results cannot be stalled.
module triangle_raster_zbuffer
    import trz_pkg::*;
#(
    parameter int FRAME_WIDTH  = TRZ_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = TRZ_FRAME_HEIGHT,
    parameter int DEPTH_BITS   = TRZ_DEPTH_BITS,
    parameter int TEX_BITS     = TRZ_TEX_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             mode,
    input  logic [1:0]                       vertex_slot,
    input  logic signed [TRZ_COORD_BITS-1:0] vertex_x,
    input  logic signed [TRZ_COORD_BITS-1:0] vertex_y,
    input  logic signed [DEPTH_BITS-1:0]     vertex_depth,
    input  logic [TEX_BITS-1:0]              vertex_u,
    input  logic [TEX_BITS-1:0]              vertex_v,
    input  logic                             cfg_write,
    input  logic                             cfg_index,
    input  logic [TRZ_CFG_BITS-1:0]          cfg_data,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [TRZ_PIX_BITS-1:0]          pixel_x,
    output logic [TRZ_PIX_BITS-1:0]          pixel_y,
    output logic signed [DEPTH_BITS-1:0]     pixel_depth,
    output logic [TEX_BITS-1:0]              pixel_u,
    output logic [TEX_BITS-1:0]              pixel_v,
    output logic                             last
);

    localparam int XW     = $clog2(FRAME_WIDTH);
    localparam int YW     = $clog2(FRAME_HEIGHT);
    localparam int DEPTHS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW     = $clog2(DEPTHS);
    localparam int CW     = TRZ_COORD_BITS;
    localparam int DFW    = CW + 1;
    localparam int DW     = TRZ_AREA_BITS;
    localparam int MA0    = (DEPTH_BITS > TEX_BITS + 1) ? DEPTH_BITS : TEX_BITS + 1;
    localparam int MA     = (MA0 > DFW) ? MA0 : DFW;
    localparam int MB     = DW;
    localparam int PW     = MA + MB;
    localparam int NW     = PW + 2;
    localparam int QB     = (DEPTH_BITS > TEX_BITS) ? DEPTH_BITS : TEX_BITS;
    localparam int QCW    = $clog2(QB + 1);
    localparam int RW     = DW + 1;
    localparam int EW     = 11;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BOX, S_MUL, S_CHECK, S_ATTR, S_DIV_INIT, S_DIV, S_DIV_END, S_CMP
    } state_t;

    typedef enum logic [1:0] {ATTR_Z, ATTR_U, ATTR_V} attr_t;

    state_t                   state_reg;
    attr_t                    attr_reg;
    logic [2:0]               cnt_reg;
    logic                     phase_reg;
    logic                     area_mode_reg;
    logic [QCW-1:0]           div_cnt_reg;
    logic [AW-1:0]            clr_cnt_reg;
    logic                     scan_active_reg;
    logic [TRZ_CFG_BITS-1:0]  frame_w_reg;
    logic [TRZ_CFG_BITS-1:0]  frame_h_reg;

    logic signed [CW-1:0]         vx_reg [3];
    logic signed [CW-1:0]         vy_reg [3];
    logic signed [DEPTH_BITS-1:0] vz_reg [3];
    logic [TEX_BITS-1:0]          vu_reg [3];
    logic [TEX_BITS-1:0]          vv_reg [3];

    logic [XW-1:0]            box_x0_reg, box_x1_reg, pos_x_reg;
    logic [YW-1:0]            box_y0_reg, box_y1_reg, pos_y_reg;
    logic signed [DW-1:0]     area_reg;
    logic [DW-1:0]            dmag_reg;
    logic signed [DW-1:0]     w_reg [3];
    logic signed [PW-1:0]     prod_reg;
    logic signed [NW-1:0]     acc_reg;
    logic                     neg_reg;
    logic [RW-1:0]            rem_reg;
    logic [QB-1:0]            quo_reg;
    logic signed [DEPTH_BITS-1:0] res_z_reg;
    logic [TEX_BITS-1:0]      res_u_reg, res_v_reg;
    logic [AW-1:0]            mem_addr_reg;
    logic signed [DEPTH_BITS-1:0] rd_data_reg;

    logic                     done_reg, last_reg;
    status_t                  status_reg;
    logic [TRZ_PIX_BITS-1:0]  px_reg, py_reg;
    logic signed [DEPTH_BITS-1:0] pz_reg;
    logic [TEX_BITS-1:0]      pu_reg, pv_reg;

    logic signed [DEPTH_BITS-1:0] depth_mem [DEPTHS];

    // frame limits and bounding box
    logic [EW-1:0]        fw_ext, fh_ext, eff_w, eff_h;
    logic signed [DFW-1:0] lim_x, lim_y, lo_x, lo_y, hi_x, hi_y;

    always_comb
    begin
        fw_ext = EW'(frame_w_reg);
        fh_ext = EW'(frame_h_reg);
        eff_w = (fw_ext == '0) ? EW'(1) :
                (fw_ext > EW'(FRAME_WIDTH)) ? EW'(FRAME_WIDTH) : fw_ext;
        eff_h = (fh_ext == '0) ? EW'(1) :
                (fh_ext > EW'(FRAME_HEIGHT)) ? EW'(FRAME_HEIGHT) : fh_ext;
        lim_x = $signed(DFW'(eff_w)) - DFW'(1);
        lim_y = $signed(DFW'(eff_h)) - DFW'(1);
        lo_x = lim_x;
        lo_y = lim_y;
        hi_x = '0;
        hi_y = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (DFW'(vx_reg[i]) < lo_x) lo_x = DFW'(vx_reg[i]);
            if (DFW'(vy_reg[i]) < lo_y) lo_y = DFW'(vy_reg[i]);
            if (DFW'(vx_reg[i]) > hi_x) hi_x = DFW'(vx_reg[i]);
            if (DFW'(vy_reg[i]) > hi_y) hi_y = DFW'(vy_reg[i]);
        end
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (hi_x > lim_x) hi_x = lim_x;
        if (hi_y > lim_y) hi_y = lim_y;
    end

    // operand selection for the shared multiplier
    logic signed [CW-1:0]  ea_x, ea_y, eb_x, eb_y;
    logic signed [DFW-1:0] pt_x, pt_y, dx, dy, qx, qy, edge_a, edge_b;
    logic signed [MA-1:0]  attr_val, mul_a;
    logic signed [MB-1:0]  w_sel, mul_b;
    logic signed [PW-1:0]  product;

    always_comb
    begin
        case (cnt_reg)
            3'd0, 3'd1:
            begin
                ea_x = vx_reg[1]; ea_y = vy_reg[1]; eb_x = vx_reg[2]; eb_y = vy_reg[2];
            end
            3'd2, 3'd3:
            begin
                ea_x = vx_reg[2]; ea_y = vy_reg[2]; eb_x = vx_reg[0]; eb_y = vy_reg[0];
            end
            default:
            begin
                ea_x = vx_reg[0]; ea_y = vy_reg[0]; eb_x = vx_reg[1]; eb_y = vy_reg[1];
            end
        endcase
        pt_x = area_mode_reg ? DFW'(vx_reg[0]) : $signed({1'b0, CW'(pos_x_reg)});
        pt_y = area_mode_reg ? DFW'(vy_reg[0]) : $signed({1'b0, CW'(pos_y_reg)});
        dx = DFW'(eb_x) - DFW'(ea_x);
        dy = DFW'(eb_y) - DFW'(ea_y);
        qx = pt_x - DFW'(ea_x);
        qy = pt_y - DFW'(ea_y);
        edge_a = cnt_reg[0] ? dy : dx;
        edge_b = cnt_reg[0] ? qx : qy;

        case (cnt_reg)
            3'd0:    w_sel = w_reg[0];
            3'd1:    w_sel = w_reg[1];
            default: w_sel = w_reg[2];
        endcase
        case (attr_reg)
            ATTR_Z:
            begin
                case (cnt_reg)
                    3'd0:    attr_val = MA'(vz_reg[0]);
                    3'd1:    attr_val = MA'(vz_reg[1]);
                    default: attr_val = MA'(vz_reg[2]);
                endcase
            end
            ATTR_U:
            begin
                case (cnt_reg)
                    3'd0:    attr_val = $signed(MA'(vu_reg[0]));
                    3'd1:    attr_val = $signed(MA'(vu_reg[1]));
                    default: attr_val = $signed(MA'(vu_reg[2]));
                endcase
            end
            default:
            begin
                case (cnt_reg)
                    3'd0:    attr_val = $signed(MA'(vv_reg[0]));
                    3'd1:    attr_val = $signed(MA'(vv_reg[1]));
                    default: attr_val = $signed(MA'(vv_reg[2]));
                endcase
            end
        endcase
        mul_a = (state_reg == S_ATTR) ? attr_val : MA'(edge_a);
        mul_b = (state_reg == S_ATTR) ? w_sel : MB'(edge_b);
        product = mul_a * mul_b;
    end

    // edge result, sign fix-up and inside test
    logic signed [NW-1:0] edge_diff, acc_sum, acc_abs;
    logic signed [DW-1:0] edge_res;
    logic signed [DW-1:0] w_adj [3];
    logic                 in_tri;

    always_comb
    begin
        edge_diff = acc_reg - NW'(prod_reg);
        edge_res = edge_diff[DW-1:0];
        acc_sum = acc_reg + NW'(prod_reg);
        acc_abs = acc_reg[NW-1] ? -acc_reg : acc_reg;
        for (int i = 0; i < 3; i++)
        begin
            w_adj[i] = area_reg[DW-1] ? -w_reg[i] : w_reg[i];
        end
        in_tri = (area_reg != '0) && !w_adj[0][DW-1] && !w_adj[1][DW-1] && !w_adj[2][DW-1];
    end

    // divider step and final sign
    logic [RW:0]   trial;
    logic [QB-1:0] quo_signed;

    always_comb
    begin
        trial = {rem_reg, quo_reg[QB-1]} - {2'b00, dmag_reg};
        quo_signed = neg_reg ? -quo_reg : quo_reg;
    end

    // scan position, pixel address and depth compare
    logic          at_end, col_end, z_wins, mem_we;
    logic [AW-1:0] pix_addr, mem_waddr;
    logic signed [DEPTH_BITS-1:0] mem_wdata;
    logic [15:0]   pos_x_w, pos_y_w;

    always_comb
    begin
        at_end = (pos_x_reg >= box_x1_reg) && (pos_y_reg >= box_y1_reg);
        col_end = pos_y_reg >= box_y1_reg;
        pix_addr = AW'(pos_x_reg) * AW'(FRAME_HEIGHT) + AW'(pos_y_reg);
        pos_x_w = 16'(pos_x_reg);
        pos_y_w = 16'(pos_y_reg);
        z_wins = res_z_reg > rd_data_reg;
        mem_we = (state_reg == S_CLEAR) || ((state_reg == S_CMP) && z_wins);
        mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : mem_addr_reg;
        mem_wdata = (state_reg == S_CLEAR) ? DEPTH_MIN : res_z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= depth_mem[mem_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            attr_reg        <= ATTR_Z;
            cnt_reg         <= '0;
            phase_reg       <= 1'b0;
            area_mode_reg   <= 1'b0;
            div_cnt_reg     <= '0;
            clr_cnt_reg     <= '0;
            scan_active_reg <= 1'b0;
            frame_w_reg     <= TRZ_CFG_BITS'(256);
            frame_h_reg     <= TRZ_CFG_BITS'(256);
            box_x0_reg      <= '0;
            box_x1_reg      <= '0;
            box_y0_reg      <= '0;
            box_y1_reg      <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            area_reg        <= '0;
            done_reg        <= 1'b0;
            status_reg      <= ST_NONE;
            last_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_w_reg <= cfg_data;
                    default:          frame_h_reg <= cfg_data;
                endcase
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTHS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (start)
                    begin
                        if (mode == MODE_LOAD && vertex_slot != SLOT_NONE)
                        begin
                            vx_reg[vertex_slot] <= vertex_x;
                            vy_reg[vertex_slot] <= vertex_y;
                            vz_reg[vertex_slot] <= vertex_depth;
                            vu_reg[vertex_slot] <= vertex_u;
                            vv_reg[vertex_slot] <= vertex_v;
                            scan_active_reg <= 1'b0;
                        end
                        if (mode == MODE_LOAD && vertex_slot == SLOT_START)
                        begin
                            state_reg <= S_BOX;
                        end
                        else if (mode == MODE_STEP && scan_active_reg)
                        begin
                            area_mode_reg <= 1'b0;
                            cnt_reg <= '0;
                            phase_reg <= 1'b0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                            status_reg <= ST_NONE;
                            px_reg <= '0;
                            py_reg <= '0;
                            pz_reg <= '0;
                            pu_reg <= '0;
                            pv_reg <= '0;
                            last_reg <= 1'b0;
                        end
                    end
                end

                S_BOX:
                begin
                    box_x0_reg <= lo_x[XW-1:0];
                    box_y0_reg <= lo_y[YW-1:0];
                    box_x1_reg <= hi_x[XW-1:0];
                    box_y1_reg <= hi_y[YW-1:0];
                    pos_x_reg <= lo_x[XW-1:0];
                    pos_y_reg <= lo_y[YW-1:0];
                    area_mode_reg <= 1'b1;
                    cnt_reg <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg <= product;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        cnt_reg <= cnt_reg + 3'd1;
                        if (!cnt_reg[0])
                        begin
                            acc_reg <= NW'(prod_reg);
                        end
                        else if (area_mode_reg)
                        begin
                            area_reg <= edge_res;
                            scan_active_reg <= 1'b1;
                            done_reg <= 1'b1;
                            status_reg <= ST_NONE;
                            px_reg <= '0;
                            py_reg <= '0;
                            pz_reg <= '0;
                            pu_reg <= '0;
                            pv_reg <= '0;
                            last_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            w_reg[cnt_reg[2:1]] <= edge_res;
                            if (cnt_reg == 3'd5)
                            begin
                                state_reg <= S_CHECK;
                            end
                        end
                    end
                end

                S_CHECK:
                begin
                    dmag_reg <= area_reg[DW-1] ? DW'(-area_reg) : DW'(area_reg);
                    if (in_tri)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            w_reg[i] <= w_adj[i];
                        end
                        mem_addr_reg <= pix_addr;
                        attr_reg <= ATTR_Z;
                        cnt_reg <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_ATTR;
                    end
                    else
                    begin
                        done_reg <= 1'b1;
                        status_reg <= ST_OUTSIDE;
                        px_reg <= pos_x_w[TRZ_PIX_BITS-1:0];
                        py_reg <= pos_y_w[TRZ_PIX_BITS-1:0];
                        pz_reg <= '0;
                        pu_reg <= '0;
                        pv_reg <= '0;
                        last_reg <= at_end;
                        if (at_end)
                        begin
                            scan_active_reg <= 1'b0;
                        end
                        else if (col_end)
                        begin
                            pos_y_reg <= box_y0_reg;
                            pos_x_reg <= pos_x_reg + XW'(1);
                        end
                        else
                        begin
                            pos_y_reg <= pos_y_reg + YW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_ATTR:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg <= product;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        acc_reg <= (cnt_reg == 3'd0) ? NW'(prod_reg) : acc_sum;
                        if (cnt_reg == 3'd2)
                        begin
                            cnt_reg <= '0;
                            state_reg <= S_DIV_INIT;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 3'd1;
                        end
                    end
                end

                S_DIV_INIT:
                begin
                    neg_reg <= acc_reg[NW-1];
                    rem_reg <= RW'(acc_abs >> QB);
                    quo_reg <= acc_abs[QB-1:0];
                    div_cnt_reg <= '0;
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (!trial[RW])
                    begin
                        rem_reg <= trial[RW-1:0];
                        quo_reg <= {quo_reg[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[RW-2:0], quo_reg[QB-1]};
                        quo_reg <= {quo_reg[QB-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + QCW'(1);
                    if (div_cnt_reg == QCW'(QB - 1))
                    begin
                        state_reg <= S_DIV_END;
                    end
                end

                S_DIV_END:
                begin
                    case (attr_reg)
                        ATTR_Z:
                        begin
                            res_z_reg <= $signed(quo_signed[DEPTH_BITS-1:0]);
                            attr_reg <= ATTR_U;
                            state_reg <= S_ATTR;
                        end
                        ATTR_U:
                        begin
                            res_u_reg <= quo_signed[TEX_BITS-1:0];
                            attr_reg <= ATTR_V;
                            state_reg <= S_ATTR;
                        end
                        default:
                        begin
                            res_v_reg <= quo_signed[TEX_BITS-1:0];
                            state_reg <= S_CMP;
                        end
                    endcase
                end

                S_CMP:
                begin
                    done_reg <= 1'b1;
                    status_reg <= z_wins ? ST_WRITTEN : ST_HIDDEN;
                    px_reg <= pos_x_w[TRZ_PIX_BITS-1:0];
                    py_reg <= pos_y_w[TRZ_PIX_BITS-1:0];
                    pz_reg <= res_z_reg;
                    pu_reg <= res_u_reg;
                    pv_reg <= res_v_reg;
                    last_reg <= at_end;
                    if (at_end)
                    begin
                        scan_active_reg <= 1'b0;
                    end
                    else if (col_end)
                    begin
                        pos_y_reg <= box_y0_reg;
                        pos_x_reg <= pos_x_reg + XW'(1);
                    end
                    else
                    begin
                        pos_y_reg <= pos_y_reg + YW'(1);
                    end
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_depth = pz_reg;
    assign pixel_u     = pu_reg;
    assign pixel_v     = pv_reg;
    assign last        = last_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done_reg)
        else $error("result during depth clear");

    a_written_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_WRITTEN) |-> $past(state_reg == S_CMP))
        else $error("written status without depth compare");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> !scan_active_reg)
        else $error("scan still active after last pixel");

    a_pos_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        scan_active_reg |-> (pos_x_reg <= box_x1_reg && pos_y_reg <= box_y1_reg
                             && pos_y_reg >= box_y0_reg && pos_x_reg >= box_x0_reg))
        else $error("scan position left the box");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg < QCW'(QB)))
        else $error("divider ran too long");

endmodule

// File: bench/tb_triangle_raster_zbuffer.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_raster_zbuffer: vertex loads, pixel steps and frame sizes.
// Depends on trz_pkg and the block; predicts every transaction and compares field by field.
module tb_triangle_raster_zbuffer;
    import trz_pkg::*;

    localparam int FW = TRZ_FRAME_WIDTH;
    localparam int FH = TRZ_FRAME_HEIGHT;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    typedef struct {
        logic        mode;
        logic [1:0]  slot;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [15:0] z;
        logic [9:0]  u;
        logic [9:0]  v;
    } vertex_cmd_t;

    typedef struct {
        status_t     st;
        logic [7:0]  px;
        logic [7:0]  py;
        logic signed [15:0] pz;
        logic [9:0]  pu;
        logic [9:0]  pv;
        logic        lst;
    } pixel_res_t;

    typedef struct {
        vertex_cmd_t cmd;
        logic        typed;
        pixel_res_t  res;
    } table_row_t;

    logic clk, rst_n, start, busy, mode, cfg_write, cfg_index, done, last;
    logic [1:0] vertex_slot, status;
    logic signed [11:0] vertex_x, vertex_y;
    logic signed [15:0] vertex_depth, pixel_depth;
    logic [9:0] vertex_u, vertex_v, pixel_u, pixel_v;
    logic [8:0] cfg_data;
    logic [7:0] pixel_x, pixel_y;

    triangle_raster_zbuffer DUT (.*);

    // predictor state
    longint vx[3], vy[3], vz[3], vu[3], vv[3];
    longint bx0, bx1, by0, by1, cx, cy, twice_area;
    bit     scanning;
    longint zbuf[FW*FH];
    longint fw_reg, fh_reg;

    pixel_res_t pending_pixels[$];
    int     failures;
    longint cycles;
    int     sent, seen, pixels_hit, idle_pct;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint edge_weight(int a, int b, longint px, longint py);
        return (vx[b]-vx[a])*(py-vy[a]) - (vy[b]-vy[a])*(px-vx[a]);
    endfunction

    function automatic longint clamp_size(longint r);
        if (r < 1) return 1;
        if (r > 256) return 256;
        return r;
    endfunction

    function automatic pixel_res_t rasterise(vertex_cmd_t c);
        pixel_res_t r;
        longint w, h, d, wa, wb, wc, oz, ou, ov;
        int idx;
        r = '{ST_NONE, 0, 0, 0, 0, 0, 0};
        if (c.mode == MODE_LOAD)
        begin
            if (c.slot != SLOT_NONE)
            begin
                vx[c.slot] = c.x; vy[c.slot] = c.y; vz[c.slot] = c.z;
                vu[c.slot] = c.u; vv[c.slot] = c.v;
                scanning = 0;
                if (c.slot == SLOT_START)
                begin
                    w = clamp_size(fw_reg); h = clamp_size(fh_reg);
                    bx0 = w-1; by0 = h-1; bx1 = 0; by1 = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (vx[i] < bx0) bx0 = vx[i];
                        if (vy[i] < by0) by0 = vy[i];
                        if (vx[i] > bx1) bx1 = vx[i];
                        if (vy[i] > by1) by1 = vy[i];
                    end
                    if (bx0 < 0) bx0 = 0;
                    if (by0 < 0) by0 = 0;
                    if (bx1 > w-1) bx1 = w-1;
                    if (by1 > h-1) by1 = h-1;
                    cx = bx0; cy = by0;
                    twice_area = edge_weight(1, 2, vx[0], vy[0]);
                    scanning = 1;
                end
            end
        end
        else if (scanning)
        begin
            d = twice_area;
            wa = edge_weight(1, 2, cx, cy);
            wb = edge_weight(2, 0, cx, cy);
            wc = edge_weight(0, 1, cx, cy);
            r.st = ST_OUTSIDE; r.px = cx; r.py = cy;
            if (d < 0)
            begin
                d = -d; wa = -wa; wb = -wb; wc = -wc;
            end
            if (d != 0 && wa >= 0 && wb >= 0 && wc >= 0)
            begin
                oz = (vz[0]*wa + vz[1]*wb + vz[2]*wc) / d;
                ou = (vu[0]*wa + vu[1]*wb + vu[2]*wc) / d;
                ov = (vv[0]*wa + vv[1]*wb + vv[2]*wc) / d;
                r.pz = oz; r.pu = ou; r.pv = ov;
                idx = cx*FH + cy;
                if (oz > zbuf[idx])
                begin
                    zbuf[idx] = oz;
                    r.st = ST_WRITTEN;
                end
                else
                    r.st = ST_HIDDEN;
            end
            if (cx >= bx1 && cy >= by1)
            begin
                r.lst = 1;
                scanning = 0;
            end
            else if (cy >= by1)
            begin
                cy = by0; cx++;
            end
            else
                cy++;
        end
        return r;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_res_t e;
        if (rst_n && done)
        begin
            seen++;
            if (pending_pixels.size() == 0)
            begin
                $error("result with nothing expected");
                failures++;
            end
            else
            begin
                e = pending_pixels.pop_front();
                compare_field("status", e.st, status);
                compare_field("pixel_x", e.px, pixel_x);
                compare_field("pixel_y", e.py, pixel_y);
                compare_field("pixel_depth", e.pz, pixel_depth);
                compare_field("pixel_u", e.pu, pixel_u);
                compare_field("pixel_v", e.pv, pixel_v);
                compare_field("last", e.lst, last);
                if (e.st == ST_WRITTEN) pixels_hit++;
            end
        end
    end

    task automatic issue(vertex_cmd_t c, bit typed, pixel_res_t tr);
        pixel_res_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1; mode <= c.mode; vertex_slot <= c.slot;
        vertex_x <= c.x; vertex_y <= c.y; vertex_depth <= c.z;
        vertex_u <= c.u; vertex_v <= c.v;
        @(posedge clk);
        while (busy) @(posedge clk);
        p = rasterise(c);
        if (typed && p != tr)
        begin
            $error("table row disagrees with prediction");
            failures++;
        end
        pending_pixels.push_back(p);
        sent++;
    endtask

    task automatic drain();
        start <= 0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_frame(logic idx, logic [8:0] val);
        cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        if (idx == CFG_FRAME_WIDTH) fw_reg = val; else fh_reg = val;
        @(posedge clk);
    endtask

    function automatic vertex_cmd_t vload(logic [1:0] s, int x, int y, int z, int u, int v);
        vertex_cmd_t c;
        c = '{MODE_LOAD, s, x, y, z, u, v};
        return c;
    endfunction

    function automatic vertex_cmd_t vstep();
        vertex_cmd_t c;
        c = '{MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return c;
    endfunction

    task automatic random_triangle(int span);
        int ox, oy, n;
        bit offs;
        offs = ($urandom_range(9) == 0);
        ox = offs ? $urandom_range(4095) - 2048 : $urandom_range(255);
        oy = offs ? $urandom_range(4095) - 2048 : $urandom_range(255);
        for (int s = 0; s < 3; s++)
            issue(vload(s, ox + $urandom_range(2*span) - span, oy + $urandom_range(2*span) - span,
                        $urandom, $urandom, $urandom), 0, '{ST_NONE, 0, 0, 0, 0, 0, 0});
        n = $urandom_range(40);
        for (int i = 0; i < n && scanning; i++)
            issue(vstep(), 0, '{ST_NONE, 0, 0, 0, 0, 0, 0});
        if ($urandom_range(9) == 0)
            issue(vload(SLOT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom), 0,
                  '{ST_NONE, 0, 0, 0, 0, 0, 0});
    endtask

    table_row_t stim_table[$];
    pixel_res_t none_res, no_check;
    int phase_pct[4] = '{0, 77, 77, 11};

    initial
    begin
        cycles = 0; failures = 0; sent = 0; seen = 0; pixels_hit = 0; idle_pct = 0;
        start = 0; mode = 0; vertex_slot = 0; vertex_x = 0; vertex_y = 0; vertex_depth = 0;
        vertex_u = 0; vertex_v = 0; cfg_write = 0; cfg_index = 0; cfg_data = 0;
        scanning = 0; bx0 = 0; bx1 = 0; by0 = 0; by1 = 0; cx = 0; cy = 0; twice_area = 0;
        fw_reg = 256; fh_reg = 256;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = 0; vy[i] = 0; vz[i] = 0; vu[i] = 0; vv[i] = 0;
        end
        foreach (zbuf[i]) zbuf[i] = -32768;
        none_res = '{ST_NONE, 0, 0, 0, 0, 0, 0};
        no_check = none_res;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: idle step, slot 3, extremes, flat and off-screen boxes
        stim_table = '{
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, SLOT_NONE, 12'sh7FF, 12'sh800, 16'sh7FFF, 10'h3FF, 10'h3FF}, 1, none_res},
            '{'{MODE_LOAD, 0, 0, 0, 16'sh7FFF, 10'h3FF, 0}, 1, none_res},
            '{'{MODE_LOAD, 1, 0, 3, 16'sh8000, 0, 10'h3FF}, 1, none_res},
            '{'{MODE_LOAD, 2, 3, 0, 16'sh7FFF, 10'h3FF, 10'h3FF}, 1, none_res},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 0, no_check},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 0, no_check},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 0, no_check},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 0, no_check},
            '{'{MODE_LOAD, 0, 5, 5, 100, 1, 1}, 1, none_res},
            '{'{MODE_LOAD, 1, 6, 6, 100, 1, 1}, 1, none_res},
            '{'{MODE_LOAD, 2, 7, 7, 100, 1, 1}, 1, none_res},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 1, '{ST_OUTSIDE, 5, 5, 0, 0, 0, 0}},
            '{'{MODE_LOAD, 0, 12'sh800, 12'sh800, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, 1, 12'sh801, 12'sh800, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, 2, 12'sh800, 12'sh801, 0, 0, 0}, 1, none_res},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 1, '{ST_OUTSIDE, 0, 0, 0, 0, 0, 1}},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, 0, 12'sh7FF, 12'sh7FF, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, 1, 12'sh7FE, 12'sh7FF, 0, 0, 0}, 1, none_res},
            '{'{MODE_LOAD, 2, 12'sh7FF, 12'sh7FE, 0, 0, 0}, 1, none_res},
            '{'{MODE_STEP, 0, 0, 0, 0, 0, 0}, 1, '{ST_OUTSIDE, 255, 255, 0, 0, 0, 1}}
        };
        foreach (stim_table[i])
            issue(stim_table[i].cmd, stim_table[i].typed, stim_table[i].res);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_pct[ph];
            case (ph)
                0: begin write_frame(CFG_FRAME_WIDTH, 9'd1); write_frame(CFG_FRAME_HEIGHT, 9'd0); end
                1: begin write_frame(CFG_FRAME_WIDTH, 9'd16); write_frame(CFG_FRAME_HEIGHT, 9'd9); end
                2: begin write_frame(CFG_FRAME_WIDTH, 9'd511); write_frame(CFG_FRAME_HEIGHT, 9'd256); end
                default: begin write_frame(CFG_FRAME_WIDTH, 9'd256); write_frame(CFG_FRAME_HEIGHT, 9'd200); end
            endcase
            while (sent < 22 + (ph + 1) * 225)
            begin
                random_triangle($urandom_range(3) == 0 ? 40 : 6);
                if ($urandom_range(30) == 0)
                    drain();
            end
            drain();
        end

        $display("Sent %0d transactions, checked %0d results, %0d depth writes.",
                 sent, seen, pixels_hit);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
